>>> rtl/core/ktre_pkg.sv
package ktre_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_REP
    } ktre_state_t;

    // Per-key entry: down flag, held time, next repeat time (both times in microseconds)
    typedef struct packed {
        logic        held;
        logic [31:0] held_time;
        logic [31:0] next_time;
    } key_entry_t;

    localparam logic [1:0] EV_PRESSED  = 2'd0;
    localparam logic [1:0] EV_RELEASED = 2'd1;
    localparam logic [1:0] EV_REPEATED = 2'd2;

    localparam logic MODE_PRESS = 1'b0;
    localparam logic MODE_POLL  = 1'b1;

    localparam logic [7:0] REG_INITIAL_DELAY   = 8'd0;
    localparam logic [7:0] REG_REPEAT_INTERVAL = 8'd1;

    localparam logic [23:0] INITIAL_DELAY_RESET   = 24'd500000;
    localparam logic [23:0] REPEAT_INTERVAL_RESET = 24'd33000;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

>>> rtl/core/ktre_key_ram.sv
module ktre_key_ram
    import ktre_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int AW    = 9
)
(
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  key_entry_t      wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output key_entry_t      rdata
);

    key_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/key_typematic_repeat_engine.sv
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_ready    mode, key_code, level_down, elapsed_us
// out       source     out_valid / out_ready  event_kind, key_id, last
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time. A press or release is done in the look step; a poll of a held key
// also runs the repeat step, one repeat per cycle while the output slot is free; the key memory
// is read for the look step and written back, with the saturating add and compare in the repeat step.
// After reset a clearing pass zeroes every key memory entry; no item is
// accepted during it, configuration writes are always taken.
// A stalled output holds the engine only in a step that has an event to load, until the pending event is taken.
module key_typematic_repeat_engine
    import ktre_pkg::*;
#(
    parameter int NUM_KEYS    = 512,
    parameter int MAX_REPEATS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [9:0]  key_code,
    input  logic        level_down,
    input  logic [19:0] elapsed_us,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic [9:0]  key_id,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int KW = $clog2(NUM_KEYS);
    localparam int CW = $clog2(MAX_REPEATS + 1);

    ktre_state_t state_reg, state_next;
    logic [KW-1:0] clr_addr_reg, clr_addr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   held_reg, held_next;
    logic [31:0]   next_reg, next_next;

    logic          mode_reg;
    logic [9:0]    key_reg;
    logic          level_reg;
    logic [19:0]   elapsed_reg;
    logic          tracked_reg;

    logic [23:0]   delay_reg;
    logic [23:0]   interval_reg;

    logic          out_valid_reg;
    logic [1:0]    out_kind_reg;
    logic [9:0]    out_key_reg;
    logic          out_last_reg;

    logic          in_accept;
    logic          slot_free;
    logic          load;
    logic [1:0]    load_kind;
    logic          load_last;

    logic          ram_we;
    logic [KW-1:0] ram_waddr;
    key_entry_t    ram_wdata;
    key_entry_t    ram_rdata;

    logic [31:0]   next_sum;
    logic          rep_hit;
    logic          rep_last;

    assign in_accept = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    assign out_valid  = out_valid_reg;
    assign event_kind = out_kind_reg;
    assign key_id     = out_key_reg;
    assign last       = out_last_reg;

    ktre_key_ram #(
        .DEPTH (NUM_KEYS),
        .AW    (KW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (key_code[KW-1:0]),
        .rdata (ram_rdata)
    );

    // Zero interval re-arms from the held time with the initial delay
    assign next_sum = (interval_reg == 24'd0) ? sat_add(held_reg, {8'd0, delay_reg})
                                              : sat_add(next_reg, {8'd0, interval_reg});
    assign rep_hit  = held_reg >= next_reg;
    assign rep_last = (interval_reg == 24'd0)
                   || ((count_reg + 1'b1) == CW'(MAX_REPEATS))
                   || (held_reg < next_sum);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        count_next    = count_reg;
        held_next     = held_reg;
        next_next     = next_reg;
        in_ready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = key_reg[KW-1:0];
        ram_wdata     = '0;
        load          = 1'b0;
        load_kind     = EV_PRESSED;
        load_last     = 1'b1;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == KW'(NUM_KEYS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (mode_reg == MODE_PRESS)
                begin
                    if (slot_free)
                    begin
                        load      = 1'b1;
                        load_kind = EV_PRESSED;
                        ram_we    = tracked_reg;
                        ram_wdata = '{held: 1'b1, held_time: 32'd0,
                                      next_time: {8'd0, delay_reg}};
                        state_next = ST_IDLE;
                    end
                end
                else if (!tracked_reg || !ram_rdata.held)
                begin
                    state_next = ST_IDLE;
                end
                else if (!level_reg)
                begin
                    if (slot_free)
                    begin
                        load       = 1'b1;
                        load_kind  = EV_RELEASED;
                        ram_we     = 1'b1;
                        ram_wdata  = '0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    held_next  = sat_add(ram_rdata.held_time, {12'd0, elapsed_reg});
                    next_next  = ram_rdata.next_time;
                    count_next = '0;
                    state_next = ST_REP;
                end
            end
            ST_REP:
            begin
                if (!rep_hit)
                begin
                    // nothing crossed: write back the grown held time only
                    ram_we     = 1'b1;
                    ram_wdata  = '{held: 1'b1, held_time: held_reg, next_time: next_reg};
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    load       = 1'b1;
                    load_kind  = EV_REPEATED;
                    load_last  = rep_last;
                    next_next  = next_sum;
                    count_next = count_reg + 1'b1;
                    if (rep_last)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = '{held: 1'b1, held_time: held_reg, next_time: next_sum};
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            delay_reg     <= INITIAL_DELAY_RESET;
            interval_reg  <= REPEAT_INTERVAL_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_INITIAL_DELAY:   delay_reg    <= cfg_data;
                    REG_REPEAT_INTERVAL: interval_reg <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        held_reg  <= held_next;
        next_reg  <= next_next;
        if (in_accept)
        begin
            mode_reg    <= mode;
            key_reg     <= key_code;
            level_reg   <= level_down;
            elapsed_reg <= elapsed_us;
            tracked_reg <= {1'b0, key_code} < 11'(NUM_KEYS);
        end
        // hold the event payload apart from the next item's fields
        if (load)
        begin
            out_kind_reg <= load_kind;
            out_key_reg  <= key_reg;
            out_last_reg <= load_last;
        end
    end

endmodule

>>> rtl/core/ktre_checker.sv
module ktre_checker
    import ktre_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] event_kind,
    input logic [9:0] key_id,
    input logic       last
);

    // hold a stalled event unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(key_id)
                                    && $stable(last))
        else $error("stalled output event changed");

    // no new item while the current one still has events to come
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input taken before final event");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_kind <= EV_REPEATED)
        else $error("unknown event kind");

    // press and release are always the only event of their item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == EV_PRESSED || event_kind == EV_RELEASED) |-> last)
        else $error("press or release not marked final");

endmodule

bind key_typematic_repeat_engine ktre_checker u_ktre_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .key_id     (key_id),
    .last       (last)
);

>>> sim/key_event_checker.sv
module key_event_checker
    import ktre_pkg::*;
#(
    parameter int NUM_KEYS    = 512,
    parameter int MAX_REPEATS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        mode,
    input  logic [9:0]  key_code,
    input  logic        level_down,
    input  logic [19:0] elapsed_us,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  event_kind,
    input  logic [9:0]  key_id,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] key;
        logic       last;
    } key_event_t;

    localparam int KW = $clog2(NUM_KEYS);

    logic [23:0] delay_us;
    logic [23:0] interval_us;
    logic        key_down [NUM_KEYS];
    logic [31:0] held_us  [NUM_KEYS];
    logic [31:0] next_us  [NUM_KEYS];
    key_event_t  expected_events [$];

    // Clamp at the top of the 32-bit microsecond range.
    function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
        if (a > (32'hFFFF_FFFF - b))
            return 32'hFFFF_FFFF;
        return a + b;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic queue_event(input logic [1:0] kind, input logic [9:0] key);
        key_event_t ev;
        ev.kind = kind;
        ev.key  = key;
        ev.last = 1'b0;
        expected_events = {expected_events, ev};
    endtask

    task automatic predict_key_item(input logic m, input logic [9:0] k, input logic lvl,
                                    input logic [19:0] el);
        int          first;
        int          n;
        logic        rearmed;
        logic [31:0] held;
        logic [31:0] nxt;
        logic [KW-1:0] idx;
        key_event_t  ev;
        first = expected_events.size();
        n = 0;
        rearmed = 1'b0;
        idx = k[KW-1:0];
        if (m == MODE_PRESS)
        begin
            queue_event(EV_PRESSED, k);
            if (k < NUM_KEYS)
            begin
                key_down[idx] = 1'b1;
                held_us[idx]  = '0;
                next_us[idx]  = {8'd0, delay_us};
            end
        end
        else if (k < NUM_KEYS && key_down[idx])
        begin
            if (!lvl)
            begin
                key_down[idx] = 1'b0;
                held_us[idx]  = '0;
                next_us[idx]  = '0;
                queue_event(EV_RELEASED, k);
            end
            else
            begin
                held = add_clamped(held_us[idx], {12'd0, el});
                nxt  = next_us[idx];
                held_us[idx] = held;
                while (!rearmed && held >= nxt && n < MAX_REPEATS)
                begin
                    queue_event(EV_REPEATED, k);
                    n++;
                    if (interval_us == '0)
                    begin
                        // zero interval: one repeat, then wait a full delay again
                        nxt = add_clamped(held, {8'd0, delay_us});
                        rearmed = 1'b1;
                    end
                    else
                    begin
                        nxt = add_clamped(nxt, {8'd0, interval_us});
                    end
                end
                next_us[idx] = nxt;
            end
        end
        if (expected_events.size() > first)
        begin
            ev = expected_events[expected_events.size() - 1];
            ev.last = 1'b1;
            expected_events[expected_events.size() - 1] = ev;
        end
    endtask

    task automatic check_key_event();
        key_event_t want;
        if (expected_events.size() == 0)
        begin
            report_mismatch($sformatf("unexpected event kind %0d key %0d last %0d",
                                      event_kind, key_id, last));
        end
        else
        begin
            want = expected_events.pop_front();
            if (event_kind !== want.kind)
                report_mismatch($sformatf("event_kind %0d, expected %0d (key %0d)",
                                          event_kind, want.kind, want.key));
            if (key_id !== want.key)
                report_mismatch($sformatf("key_id %0d, expected %0d", key_id, want.key));
            if (last !== want.last)
                report_mismatch($sformatf("last %0d, expected %0d (key %0d)",
                                          last, want.last, want.key));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_us    = INITIAL_DELAY_RESET;
            interval_us = REPEAT_INTERVAL_RESET;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                key_down[i] = 1'b0;
                held_us[i]  = '0;
                next_us[i]  = '0;
            end
            expected_events.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            // retire outputs before queuing, so a fresh item never matches this edge
            if (out_valid && out_ready)
                check_key_event();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_INITIAL_DELAY)
                    delay_us = cfg_data;
                else if (cfg_index == REG_REPEAT_INTERVAL)
                    interval_us = cfg_data;
            end
            if (in_valid && in_ready)
                predict_key_item(mode, key_code, level_down, elapsed_us);
            outstanding <= expected_events.size();
        end
    end

endmodule

>>> sim/testbench.sv
module testbench
    import ktre_pkg::*;
();

    localparam int NUM_KEYS      = 512;
    localparam int MAX_REPEATS   = 16;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_OFF      = 400;
    localparam int HOLD_AFTER    = 150;
    localparam int PHASE_ITEMS   = 38;
    localparam logic [23:0] FIELD_MAX24 = 24'hFF_FFFF;
    localparam logic [19:0] FIELD_MAX20 = 20'hF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = MODE_PRESS;
    logic [9:0]  key_code = '0;
    logic        level_down = 1'b0;
    logic [19:0] elapsed_us = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  event_kind;
    logic [9:0]  key_id;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    int          mismatches;
    int          outstanding;
    logic        no_idle = 1'b0;
    int          quiet_cycles = 0;
    logic [9:0]  key_pool [8];

    always #4 clk = ~clk;

    key_typematic_repeat_engine #(
        .NUM_KEYS   (NUM_KEYS),
        .MAX_REPEATS(MAX_REPEATS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .key_code  (key_code),
        .level_down(level_down),
        .elapsed_us(elapsed_us),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .event_kind(event_kind),
        .key_id    (key_id),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    key_event_checker #(
        .NUM_KEYS   (NUM_KEYS),
        .MAX_REPEATS(MAX_REPEATS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .key_code   (key_code),
        .level_down (level_down),
        .elapsed_us (elapsed_us),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .key_id     (key_id),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    // Abort when no channel has moved an item for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up.
    initial
    begin
        int   events_taken;
        int   hold_left;
        logic hold_done;
        events_taken = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                events_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && events_taken >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= no_idle || ($urandom_range(99) >= 38);
            end
        end
    end

    task automatic send_key_item(input logic m, input logic [9:0] k, input logic lvl,
                                 input logic [19:0] el);
        while (!no_idle && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        key_code   <= k;
        level_down <= lvl;
        elapsed_us <= el;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write of a group.
    task automatic write_register(input logic [7:0] idx, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic apply_timing(input logic [23:0] delay, input logic [23:0] interval,
                                input logic stray_write);
        if (stray_write)
            write_register(8'($urandom_range(255, REG_REPEAT_INTERVAL + 1)), 24'($urandom));
        write_register(REG_INITIAL_DELAY, delay);
        write_register(REG_REPEAT_INTERVAL, interval);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every expected event, then let a trailing poll finish.
    task automatic drain_events();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [19:0] pick_elapsed();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 20'($urandom_range(50000));
        if (r < 80)
            return 20'($urandom);
        if (r < 90)
            return '0;
        return FIELD_MAX20;
    endfunction

    task automatic send_random_item();
        int r;
        r = $urandom_range(99);
        if (r < 12)
        begin
            // noise: any key, any mode, any level
            send_key_item(1'($urandom), 10'($urandom), 1'($urandom), 20'($urandom));
        end
        else
        begin
            send_key_item(($urandom_range(99) < 20) ? MODE_PRESS : MODE_POLL,
                          key_pool[$urandom_range(7)],
                          ($urandom_range(99) < 85),
                          pick_elapsed());
        end
    endtask

    initial
    begin
        logic [23:0] phase_delay [7];
        logic [23:0] phase_interval [7];

        phase_delay[0] = '0;             phase_interval[0] = '0;
        phase_delay[1] = FIELD_MAX24;    phase_interval[1] = FIELD_MAX24;
        phase_delay[2] = 24'd1;          phase_interval[2] = 24'd1;
        phase_delay[3] = 24'd250000;     phase_interval[3] = '0;
        phase_delay[4] = 24'd500000;     phase_interval[4] = 24'd33000;
        phase_delay[5] = 24'($urandom_range(1500000));
        phase_interval[5] = 24'($urandom_range(90000));
        phase_delay[6] = 24'($urandom);  phase_interval[6] = 24'($urandom);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset timing of 500000 / 33000.
        send_key_item(MODE_PRESS, 10'd0,   1'b1, FIELD_MAX20);
        send_key_item(MODE_PRESS, 10'd511, 1'b0, 20'd0);
        send_key_item(MODE_PRESS, 10'd512, 1'b1, 20'd12345);
        send_key_item(MODE_PRESS, 10'd1023, 1'b1, FIELD_MAX20);
        send_key_item(MODE_POLL,  10'd1023, 1'b1, FIELD_MAX20);   // untracked poll
        send_key_item(MODE_POLL,  10'd5,   1'b1, FIELD_MAX20);    // key not down
        send_key_item(MODE_POLL,  10'd0,   1'b1, 20'd0);
        send_key_item(MODE_POLL,  10'd0,   1'b1, FIELD_MAX20);    // hits the per-item cap
        send_key_item(MODE_POLL,  10'd0,   1'b1, 20'd0);          // pending repeat drains
        send_key_item(MODE_POLL,  10'd511, 1'b1, 20'd499999);
        send_key_item(MODE_POLL,  10'd511, 1'b1, 20'd1);          // exactly at the delay
        send_key_item(MODE_POLL,  10'd0,   1'b0, 20'd777);        // release
        send_key_item(MODE_POLL,  10'd0,   1'b0, 20'd0);          // already up
        send_key_item(MODE_PRESS, 10'd511, 1'b1, 20'd0);          // re-press while down
        send_key_item(MODE_POLL,  10'd511, 1'b1, 20'd40000);
        send_key_item(MODE_POLL,  10'd511, 1'b0, FIELD_MAX20);
        drain_events();

        // Random phases over a spread of timing settings.
        for (int p = 0; p < 7; p++)
        begin
            apply_timing(phase_delay[p], phase_interval[p], (p == 2) || (p == 5));
            key_pool[0] = 10'd0;
            key_pool[1] = 10'(NUM_KEYS - 1);
            for (int i = 2; i < 8; i++)
                key_pool[i] = 10'($urandom_range(NUM_KEYS - 1));
            no_idle = (p == 4);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random_item();
            drain_events();
        end
        no_idle = 1'b0;

        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
